>>> rtl/gtoe_pkg.sv
// Shared constants, register codes and controller/datapath interface types
// for the graph traversal order engine. No dependencies.
package gtoe_pkg;

    localparam int DEF_MAX_VERTICES = 64;

    // Fixed field widths
    localparam int VERTEX_W   = 6;
    localparam int EDGE_W     = 64;
    localparam int VCOUNT_W   = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index (paddr[2])
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_ORDER_MODE   = 1'b1;

    // Traversal order
    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Controller -> datapath commands (at most one step command per cycle)
    typedef struct packed {
        logic load_row;     // store incoming adjacency row
        logic begin_trav;   // clear visited flags, pointers, counters
        logic root_skip;    // root already visited, advance
        logic root_bfs;     // mark root, push into fifo, advance
        logic root_dfs;     // mark root, emit it, open stack, advance
        logic bfs_pop;      // take fifo head as current vertex, emit it
        logic bfs_scan;     // test neighbor j, push on hit, j++
        logic dfs_push;     // mark and emit neighbor j, descend into it
        logic dfs_step;     // j++
        logic dfs_pop;      // drop stack top
        logic dfs_restore;  // reload vertex/next-neighbor from stack
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic fifo_empty;
        logic scan_done;
        logic hit;
        logic depth_one;
    } dp_stat_t;

endpackage

>>> rtl/gtoe_dp.sv
// Datapath: adjacency, fifo and stack memories, visited flags, scan counters
// and the result register. Depends on gtoe_pkg.
module gtoe_dp #(
    parameter int MAX_VERTICES = gtoe_pkg::DEF_MAX_VERTICES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gtoe_pkg::dp_cmd_t             cmd,
    output gtoe_pkg::dp_stat_t            stat,
    input  logic [gtoe_pkg::VERTEX_W-1:0] row_number,
    input  logic [gtoe_pkg::EDGE_W-1:0]   row_edges,
    input  logic [gtoe_pkg::VCOUNT_W-1:0] vertex_count,
    output logic                          result_valid,
    output logic [gtoe_pkg::VERTEX_W-1:0] visited_vertex,
    output logic                          final_vertex
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int SW    = VW + CW;
    localparam int VTX_W = gtoe_pkg::VERTEX_W;
    localparam int CNT_W = gtoe_pkg::VCOUNT_W;
    localparam int RW    = VTX_W + 1;

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [VW-1:0]           fifo_mem [MAX_VERTICES];
    logic [SW-1:0]           stack_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] adj_rdata_reg;
    logic [VW-1:0]           fifo_rdata_reg;
    logic [SW-1:0]           stack_rdata_reg;

    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0]           cur_v_reg, cur_v_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           root_reg, root_next;
    logic [CW-1:0]           head_reg, head_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           depth_reg, depth_next;
    logic [CW-1:0]           emit_cnt_reg, emit_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]        out_vertex_reg, out_vertex_next;
    logic                    out_final_reg, out_final_next;

    logic [CW-1:0] n_eff;
    logic          row_ok;
    logic [VW-1:0] j_idx;
    logic [VW-1:0] root_idx;
    logic [VW-1:0] stack_idx;
    logic          hit;
    logic          fifo_we;
    logic [VW-1:0] fifo_wdata;
    logic          emit;
    logic [VW-1:0] emit_vertex;

    // Vertex count saturates at the configured capacity
    assign n_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : vertex_count[CW-1:0];
    assign row_ok    = ({1'b0, row_number} < RW'(MAX_VERTICES));
    assign j_idx     = j_reg[VW-1:0];
    assign root_idx  = root_reg[VW-1:0];
    assign stack_idx = VW'(depth_reg - CW'(1));
    assign hit       = adj_rdata_reg[j_idx] & ~visited_reg[j_idx];

    assign stat.root_done    = (root_reg == n_eff);
    assign stat.root_visited = visited_reg[root_idx];
    assign stat.fifo_empty   = (head_reg == tail_reg);
    assign stat.scan_done    = (j_reg == n_eff);
    assign stat.hit          = hit;
    assign stat.depth_one    = (depth_reg == CW'(1));

    assign fifo_we    = cmd.root_bfs | (cmd.bfs_scan & hit);
    assign fifo_wdata = cmd.root_bfs ? root_idx : j_idx;

    // Adjacency rows; read port follows the current vertex
    always_ff @(posedge clk)
    begin
        if (cmd.load_row && row_ok)
        begin
            adj_mem[row_number[VW-1:0]] <= row_edges[MAX_VERTICES-1:0];
        end
        adj_rdata_reg <= adj_mem[cur_v_reg];
    end

    // Breadth-first queue
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg[VW-1:0]] <= fifo_wdata;
        end
        fifo_rdata_reg <= fifo_mem[head_reg[VW-1:0]];
    end

    // Depth-first stack; the top entry lives in cur_v_reg/j_reg
    always_ff @(posedge clk)
    begin
        if (cmd.dfs_push)
        begin
            stack_mem[stack_idx] <= {cur_v_reg, j_reg + CW'(1)};
        end
        stack_rdata_reg <= stack_mem[stack_idx];
    end

    always_comb
    begin
        visited_next  = visited_reg;
        cur_v_next    = cur_v_reg;
        j_next        = j_reg;
        root_next     = root_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        depth_next    = depth_reg;
        emit          = 1'b0;
        emit_vertex   = cur_v_reg;

        if (cmd.begin_trav)
        begin
            visited_next = '0;
            head_next    = '0;
            tail_next    = '0;
            depth_next   = '0;
            root_next    = '0;
        end
        if (cmd.root_skip)
        begin
            root_next = root_reg + CW'(1);
        end
        if (cmd.root_bfs)
        begin
            visited_next[root_idx] = 1'b1;
            tail_next              = tail_reg + CW'(1);
            root_next              = root_reg + CW'(1);
        end
        if (cmd.root_dfs)
        begin
            visited_next[root_idx] = 1'b1;
            cur_v_next             = root_idx;
            j_next                 = '0;
            depth_next             = CW'(1);
            root_next              = root_reg + CW'(1);
            emit                   = 1'b1;
            emit_vertex            = root_idx;
        end
        if (cmd.bfs_pop)
        begin
            cur_v_next  = fifo_rdata_reg;
            head_next   = head_reg + CW'(1);
            j_next      = '0;
            emit        = 1'b1;
            emit_vertex = fifo_rdata_reg;
        end
        if (cmd.bfs_scan)
        begin
            if (hit)
            begin
                visited_next[j_idx] = 1'b1;
                tail_next           = tail_reg + CW'(1);
            end
            j_next = j_reg + CW'(1);
        end
        if (cmd.dfs_push)
        begin
            visited_next[j_idx] = 1'b1;
            cur_v_next          = j_idx;
            j_next              = '0;
            depth_next          = depth_reg + CW'(1);
            emit                = 1'b1;
            emit_vertex         = j_idx;
        end
        if (cmd.dfs_step)
        begin
            j_next = j_reg + CW'(1);
        end
        if (cmd.dfs_pop)
        begin
            depth_next = depth_reg - CW'(1);
        end
        if (cmd.dfs_restore)
        begin
            cur_v_next = stack_rdata_reg[SW-1:CW];
            j_next     = stack_rdata_reg[CW-1:0];
        end
    end

    // Result register; every traversal emits exactly n vertices
    always_comb
    begin
        emit_cnt_next   = cmd.begin_trav ? '0 : emit_cnt_reg;
        out_valid_next  = emit;
        out_vertex_next = VTX_W'(emit_vertex);
        out_final_next  = ((emit_cnt_reg + CW'(1)) == n_eff);
        if (emit)
        begin
            emit_cnt_next = emit_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg   <= '0;
            j_reg         <= '0;
            root_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            depth_reg     <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            visited_reg   <= visited_next;
            j_reg         <= j_next;
            root_reg      <= root_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            depth_reg     <= depth_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg      <= cur_v_next;
        out_vertex_reg <= out_vertex_next;
        out_final_reg  <= out_final_next;
    end

    assign result_valid   = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign final_vertex   = out_final_reg;

endmodule

>>> rtl/gtoe_ctrl.sv
// Controller: one-hot state machine that sequences root selection, the
// breadth-first and depth-first walks. Depends on gtoe_pkg.
module gtoe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               final_row,
    input  logic               order_mode,
    input  gtoe_pkg::dp_stat_t stat,
    output logic               busy,
    output gtoe_pkg::dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE        = 10'b0000000001,
        ST_ROOT        = 10'b0000000010,
        ST_BFS_POP     = 10'b0000000100,
        ST_BFS_EMIT    = 10'b0000001000,
        ST_BFS_LOAD    = 10'b0000010000,
        ST_BFS_SCAN    = 10'b0000100000,
        ST_DFS_LOAD    = 10'b0001000000,
        ST_DFS_SCAN    = 10'b0010000000,
        ST_DFS_POP     = 10'b0100000000,
        ST_DFS_RESTORE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load_row   = accept;
        cmd.begin_trav = accept & final_row;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && final_row)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.root_visited)
                begin
                    cmd.root_skip = 1'b1;
                end
                else if (order_mode == gtoe_pkg::MODE_DFS)
                begin
                    cmd.root_dfs = 1'b1;
                    state_next   = ST_DFS_LOAD;
                end
                else
                begin
                    cmd.root_bfs = 1'b1;
                    state_next   = ST_BFS_POP;
                end
            end
            // fifo head read settles during this cycle
            ST_BFS_POP:
            begin
                state_next = stat.fifo_empty ? ST_ROOT : ST_BFS_EMIT;
            end
            ST_BFS_EMIT:
            begin
                cmd.bfs_pop = 1'b1;
                state_next  = ST_BFS_LOAD;
            end
            ST_BFS_LOAD:
            begin
                state_next = ST_BFS_SCAN;
            end
            ST_BFS_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_BFS_POP;
                end
                else
                begin
                    cmd.bfs_scan = 1'b1;
                end
            end
            ST_DFS_LOAD:
            begin
                state_next = ST_DFS_SCAN;
            end
            ST_DFS_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.dfs_pop = 1'b1;
                    state_next  = stat.depth_one ? ST_ROOT : ST_DFS_POP;
                end
                else if (stat.hit)
                begin
                    cmd.dfs_push = 1'b1;
                    state_next   = ST_DFS_LOAD;
                end
                else
                begin
                    cmd.dfs_step = 1'b1;
                end
            end
            ST_DFS_POP:
            begin
                state_next = ST_DFS_RESTORE;
            end
            ST_DFS_RESTORE:
            begin
                cmd.dfs_restore = 1'b1;
                state_next      = ST_DFS_LOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/graph_traversal_order_engine.sv
// Top level of the graph traversal order engine: APB register file plus
// controller and datapath. Depends on gtoe_pkg, gtoe_ctrl, gtoe_dp.
//
// Usage:
//  - Input channel: an item (row_number, row_edges, final_row) is taken at a
//    rising edge with start high and busy low. Each item stores one adjacency
//    row; rows at or above MAX_VERTICES are dropped.
//  - The item with final_row set starts a traversal over vertices
//    0..vertex_count-1 (count saturates at MAX_VERTICES). busy stays high
//    until the last vertex has been sent.
//  - Result channel: one vertex per result_valid pulse, in breadth-first or
//    depth-first preorder (order_mode); final_vertex marks the last one.
//    Results cannot be held off; each stands for exactly one cycle.
//  - Timing: the first vertex is emitted from the root state (depth first)
//    or from the fifo pop (breadth first) after the final row.
//    The neighbor scan tests one adjacency bit per cycle in a scan state:
//    breadth first passes pop, emit, load and scan per vertex, depth first
//    load and scan per vertex plus pop, restore and load per return from a
//    child; the root state checks each root and ends the traversal.
//  - Registers (APB, write in setup+access, pready tied high):
//    0x0 vertex_count (7 bits, reset 64), 0x4 order_mode (1 bit, reset 0).
//    Write them only while busy is low.
//  - Reset: asynchronous, active low; clears control state and registers.
//    Adjacency rows are not cleared; every row used must be loaded first.
module graph_traversal_order_engine #(
    parameter int MAX_VERTICES = gtoe_pkg::DEF_MAX_VERTICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtoe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gtoe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gtoe_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Row input
    input  logic                            start,
    output logic                            busy,
    input  logic [gtoe_pkg::VERTEX_W-1:0]   row_number,
    input  logic [gtoe_pkg::EDGE_W-1:0]     row_edges,
    input  logic                            final_row,
    // Result output
    output logic                            result_valid,
    output logic [gtoe_pkg::VERTEX_W-1:0]   visited_vertex,
    output logic                            final_vertex
);

    localparam int DW    = gtoe_pkg::APB_DATA_W;
    localparam int CNT_W = gtoe_pkg::VCOUNT_W;

    logic [CNT_W-1:0] vertex_count_reg, vertex_count_next;
    logic             order_mode_reg, order_mode_next;
    logic             wr_en;
    logic             reg_sel;

    gtoe_pkg::dp_cmd_t  cmd;
    gtoe_pkg::dp_stat_t stat;

    // Register decode on paddr[2]; low address bits are don't-care
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        order_mode_next   = order_mode_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                gtoe_pkg::REG_VERTEX_COUNT: vertex_count_next = pwdata[CNT_W-1:0];
                gtoe_pkg::REG_ORDER_MODE:   order_mode_next   = pwdata[0];
                default:                    vertex_count_next = vertex_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            gtoe_pkg::REG_VERTEX_COUNT: prdata = DW'(vertex_count_reg);
            gtoe_pkg::REG_ORDER_MODE:   prdata = DW'(order_mode_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= gtoe_pkg::VCOUNT_RESET;
            order_mode_reg   <= gtoe_pkg::MODE_BFS;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
            order_mode_reg   <= order_mode_next;
        end
    end

    gtoe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .final_row  (final_row),
        .order_mode (order_mode_reg),
        .stat       (stat),
        .busy       (busy),
        .cmd        (cmd)
    );

    gtoe_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .row_number     (row_number),
        .row_edges      (row_edges),
        .vertex_count   (vertex_count_reg),
        .result_valid   (result_valid),
        .visited_vertex (visited_vertex),
        .final_vertex   (final_vertex)
    );

endmodule
